// ===== design/lwrf_pkg.sv =====
// Shared types, widths, register indexes and reset values for the launcher wheel control.
`timescale 1ns / 1ps

package lwrf_pkg;

    localparam int SPEED_W   = 17;
    localparam int WHEEL_W   = 18;
    localparam int STEP_W    = 16;
    localparam int FACTOR_W  = 8;
    localparam int FEED_W    = 20;
    localparam int PERIOD_W  = 8;
    localparam int POS_W     = 32;
    localparam int HEAT_W    = 16;
    localparam int TICK_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int IN_BITS   = 71;
    localparam int IN_DATA_W = 72;
    localparam int OUT_BITS  = 142;
    localparam int OUT_DATA_W = 144;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SPEED_MAX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_SPEED_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PERIOD   = 3'd5;

    localparam logic [SPEED_W-1:0]  RST_INNER_SPEED_MAX = 17'd102400;
    localparam logic [SPEED_W-1:0]  RST_OUTER_SPEED_MAX = 17'd102400;
    localparam logic [STEP_W-1:0]   RST_RAMP_STEP       = 16'd1280;
    localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR    = 8'd230;
    localparam logic [FEED_W-1:0]   RST_FEED_STEP       = 20'd5787;
    localparam logic [PERIOD_W-1:0] RST_ENABLE_PERIOD   = 8'd125;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 8'd128;

    // remote switch codes
    localparam logic [1:0] SW_OFF = 2'd0;
    localparam logic [1:0] SW_ON  = 2'd1;

    typedef struct packed {
        logic [SPEED_W-1:0]  inner_speed_max;
        logic [SPEED_W-1:0]  outer_speed_max;
        logic [STEP_W-1:0]   ramp_step;
        logic [FACTOR_W-1:0] decay_factor;
        logic [FEED_W-1:0]   feed_step;
        logic [PERIOD_W-1:0] enable_period;
    } cfg_t;

    // packed so that the last field sits in the lowest bits of tdata
    typedef struct packed {
        logic signed [POS_W-1:0] motor_position;
        logic [HEAT_W-1:0]       heat_limit;
        logic [HEAT_W-1:0]       barrel_heat;
        logic                    scroll_down;
        logic                    fire_button;
        logic [1:0]              wheel_switch;
        logic                    shift_key;
        logic                    ctrl_key;
        logic                    safe_mode;
    } in_item_t;

    typedef struct packed {
        logic                      enable_pulse;
        logic                      feed_full_speed;
        logic signed [POS_W-1:0]   feed_target;
        logic signed [WHEEL_W-1:0] wheel_5;
        logic signed [WHEEL_W-1:0] wheel_4;
        logic signed [WHEEL_W-1:0] wheel_3;
        logic signed [WHEEL_W-1:0] wheel_2;
        logic signed [WHEEL_W-1:0] wheel_1;
        logic signed [WHEEL_W-1:0] wheel_0;
    } result_t;

endpackage

// ===== design/lwrf_cfg_regs.sv =====
// Configuration register file for the launcher wheel control.
`timescale 1ns / 1ps

module lwrf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lwrf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lwrf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lwrf_pkg::cfg_t                   cfg
);

    lwrf_pkg::cfg_t cfg_reg;
    lwrf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                lwrf_pkg::REG_INNER_SPEED_MAX:
                    cfg_next.inner_speed_max = cfg_wdata[lwrf_pkg::SPEED_W-1:0];
                lwrf_pkg::REG_OUTER_SPEED_MAX:
                    cfg_next.outer_speed_max = cfg_wdata[lwrf_pkg::SPEED_W-1:0];
                lwrf_pkg::REG_RAMP_STEP:
                    cfg_next.ramp_step = cfg_wdata[lwrf_pkg::STEP_W-1:0];
                lwrf_pkg::REG_DECAY_FACTOR:
                    cfg_next.decay_factor = cfg_wdata[lwrf_pkg::FACTOR_W-1:0];
                lwrf_pkg::REG_FEED_STEP:
                    cfg_next.feed_step = cfg_wdata[lwrf_pkg::FEED_W-1:0];
                lwrf_pkg::REG_ENABLE_PERIOD:
                    cfg_next.enable_period = cfg_wdata[lwrf_pkg::PERIOD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner_speed_max <= lwrf_pkg::RST_INNER_SPEED_MAX;
            cfg_reg.outer_speed_max <= lwrf_pkg::RST_OUTER_SPEED_MAX;
            cfg_reg.ramp_step       <= lwrf_pkg::RST_RAMP_STEP;
            cfg_reg.decay_factor    <= lwrf_pkg::RST_DECAY_FACTOR;
            cfg_reg.feed_step       <= lwrf_pkg::RST_FEED_STEP;
            cfg_reg.enable_period   <= lwrf_pkg::RST_ENABLE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/lwrf_core.sv =====
// Control state and per-tick update: wheel ramp/decay, feed accumulator, enable counter.
`timescale 1ns / 1ps

module lwrf_core (
    input  logic                clk,
    input  logic                rst_n,
    input  lwrf_pkg::cfg_t      cfg,
    input  logic                step,
    input  lwrf_pkg::in_item_t  item,
    output lwrf_pkg::result_t   result
);

    localparam int PROD_W = lwrf_pkg::SPEED_W + lwrf_pkg::FACTOR_W;

    logic                          wheels_on_reg, wheels_on_next;
    logic [lwrf_pkg::SPEED_W-1:0]  inner_speed_reg, inner_speed_next;
    logic [lwrf_pkg::SPEED_W-1:0]  outer_speed_reg, outer_speed_next;
    logic [lwrf_pkg::POS_W-1:0]    feed_accum_reg, feed_accum_next;
    logic [lwrf_pkg::TICK_W-1:0]   tick_count_reg, tick_count_next;

    logic                          switch_on;
    logic [lwrf_pkg::SPEED_W:0]    inner_ramp, outer_ramp;
    logic [lwrf_pkg::SPEED_W-1:0]  inner_up, outer_up;
    logic [PROD_W-1:0]             inner_prod, outer_prod;
    logic [lwrf_pkg::SPEED_W-1:0]  inner_new, outer_new;
    logic                          fire;
    logic                          overheat;
    logic [lwrf_pkg::POS_W-1:0]    accum_fired;
    logic [lwrf_pkg::PERIOD_W-1:0] eff_period;
    logic [lwrf_pkg::PERIOD_W-1:0] tick_inc;
    logic                          at_last_tick;

    // off request wins over on request; otherwise the flag holds
    always_comb
    begin
        if (item.ctrl_key || item.wheel_switch == lwrf_pkg::SW_OFF)
            switch_on = 1'b0;
        else if (item.shift_key || item.wheel_switch == lwrf_pkg::SW_ON)
            switch_on = 1'b1;
        else
            switch_on = wheels_on_reg;
    end

    // ramp with clamp, or decay by the Q0.8 factor
    always_comb
    begin
        inner_ramp = {1'b0, inner_speed_reg} + {2'b00, cfg.ramp_step};
        outer_ramp = {1'b0, outer_speed_reg} + {2'b00, cfg.ramp_step};
        inner_up = (inner_ramp > {1'b0, cfg.inner_speed_max}) ?
                   cfg.inner_speed_max : inner_ramp[lwrf_pkg::SPEED_W-1:0];
        outer_up = (outer_ramp > {1'b0, cfg.outer_speed_max}) ?
                   cfg.outer_speed_max : outer_ramp[lwrf_pkg::SPEED_W-1:0];
        inner_prod = PROD_W'(inner_speed_reg) * PROD_W'(cfg.decay_factor);
        outer_prod = PROD_W'(outer_speed_reg) * PROD_W'(cfg.decay_factor);
        inner_new = switch_on ? inner_up : inner_prod[PROD_W-1:lwrf_pkg::FACTOR_W];
        outer_new = switch_on ? outer_up : outer_prod[PROD_W-1:lwrf_pkg::FACTOR_W];
    end

    assign fire        = item.fire_button | item.scroll_down;
    assign overheat    = item.barrel_heat >= item.heat_limit;
    assign accum_fired = fire ? feed_accum_reg - {12'd0, cfg.feed_step} : feed_accum_reg;

    // clamp the period to 1..128
    always_comb
    begin
        if (cfg.enable_period == '0)
            eff_period = lwrf_pkg::PERIOD_W'(1);
        else if (cfg.enable_period > lwrf_pkg::PERIOD_MAX)
            eff_period = lwrf_pkg::PERIOD_MAX;
        else
            eff_period = cfg.enable_period;
    end

    assign tick_inc     = {1'b0, tick_count_reg} + lwrf_pkg::PERIOD_W'(1);
    assign at_last_tick = tick_inc == eff_period;

    always_comb
    begin
        wheels_on_next   = wheels_on_reg;
        inner_speed_next = inner_speed_reg;
        outer_speed_next = outer_speed_reg;
        feed_accum_next  = feed_accum_reg;
        tick_count_next  = tick_count_reg;
        if (step)
        begin
            tick_count_next = (tick_inc >= eff_period) ? '0 : tick_inc[lwrf_pkg::TICK_W-1:0];
            if (!item.safe_mode)
            begin
                wheels_on_next   = switch_on;
                inner_speed_next = inner_new;
                outer_speed_next = outer_new;
                if (!overheat)
                    feed_accum_next = accum_fired;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheels_on_reg   <= 1'b0;
            inner_speed_reg <= '0;
            outer_speed_reg <= '0;
            feed_accum_reg  <= '0;
            tick_count_reg  <= '0;
        end
        else
        begin
            wheels_on_reg   <= wheels_on_next;
            inner_speed_reg <= inner_speed_next;
            outer_speed_reg <= outer_speed_next;
            feed_accum_reg  <= feed_accum_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    always_comb
    begin
        if (item.safe_mode)
        begin
            result.wheel_0         = '0;
            result.wheel_1         = '0;
            result.wheel_2         = '0;
            result.wheel_3         = '0;
            result.wheel_4         = '0;
            result.wheel_5         = '0;
            result.feed_target     = item.motor_position;
            result.feed_full_speed = 1'b0;
            result.enable_pulse    = 1'b0;
        end
        else
        begin
            result.wheel_0         = lwrf_pkg::WHEEL_W'(0) - {1'b0, inner_new};
            result.wheel_1         = {1'b0, inner_new};
            result.wheel_2         = {1'b0, inner_new};
            result.wheel_3         = lwrf_pkg::WHEEL_W'(0) - {1'b0, outer_new};
            result.wheel_4         = {1'b0, outer_new};
            result.wheel_5         = {1'b0, outer_new};
            result.feed_target     = overheat ? item.motor_position : accum_fired;
            result.feed_full_speed = 1'b1;
            result.enable_pulse    = at_last_tick;
        end
    end

    a_pulse_wraps_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.enable_pulse |=> tick_count_reg == '0)
        else $error("tick counter did not wrap after an enable pulse");

    a_safe_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.safe_mode |=> $stable(feed_accum_reg) && $stable(wheels_on_reg)
                                   && $stable(inner_speed_reg))
        else $error("safe mode tick changed control state");

    a_ramp_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.safe_mode && switch_on
        |=> inner_speed_reg <= $past(cfg.inner_speed_max)
            && outer_speed_reg <= $past(cfg.outer_speed_max))
        else $error("ramped speed above its limit");

endmodule

// ===== design/launcher_wheel_ramp_and_feed_control_unit.sv =====
// Top level: stream ports, input and result registers around the control core.
`timescale 1ns / 1ps

// Launcher wheel ramp and feed control. Each input word is one control tick and
// produces exactly one result word. The block takes a word every clock cycle
// when the output side keeps up; a word passes an input register and then a
// result register, which drives its result on m_tdata. With m_tready low the
// input keeps accepting until both registers hold a word, then s_tready drops.
// The tick counter and, outside safe mode, the wheel speeds and feed accumulator
// update in the cycle a word moves from the input register to the result
// register, which sets the one-per-cycle rate. Configuration is written
// through cfg_wr_en/cfg_addr/cfg_wdata; the user must do so only while idle,
// as the block itself does not enforce it. Addresses beyond the register list
// are ignored.
module launcher_wheel_ramp_and_feed_control_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // safe_mode, ctrl_key, shift_key, wheel_switch[1:0], fire_button, scroll_down,
    // barrel_heat[15:0], heat_limit[15:0], motor_position[31:0], zero pad
    input  logic [lwrf_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // wheel_0..wheel_5 [17:0] each, feed_target[31:0], feed_full_speed,
    // enable_pulse, zero pad
    output logic [lwrf_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [lwrf_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [lwrf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    lwrf_pkg::cfg_t     cfg;
    lwrf_pkg::in_item_t in_reg;
    lwrf_pkg::result_t  out_reg;
    lwrf_pkg::result_t  result;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               advance;
    logic               step;
    logic               take;

    lwrf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lwrf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (in_reg),
        .result (result)
    );

    // result register free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= lwrf_pkg::in_item_t'(s_tdata[lwrf_pkg::IN_BITS-1:0]);
        if (step)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(lwrf_pkg::OUT_DATA_W - lwrf_pkg::OUT_BITS)'(0), out_reg};

    a_full_input_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed word did not reach the result register");

    a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("word dropped from the input register while stalled");

endmodule
